// ===== hdl/avcc_pkg.sv =====
package avcc_pkg;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic [19:0] packet_size;
        logic        packet_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        packet_end;
        logic [18:0] out_length;
        logic [1:0]  status;
    } out_beat_t;

    localparam int unsigned MAX_OUT_BYTES    = 262144;
    localparam int unsigned MAX_PACKET_BYTES = 1048576;

    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned RBUF_DEPTH  = 8;

    localparam logic [18:0] CAP_RESET = 19'd262144;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    typedef logic [2:0] rnum_t;

    typedef struct packed {
        rnum_t                          num;
        out_beat_t [MAX_RESULTS-1:0]    beat;
    } result_set_t;

endpackage

// ===== hdl/avcc_step.sv =====
module avcc_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  avcc_pkg::in_beat_t    s_data,
    input  logic                  cfg_wr_en,
    input  logic [18:0]           cfg_wr_data,
    input  logic                  rbuf_room,
    output logic                  push,
    output avcc_pkg::result_set_t push_set
);
    import avcc_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_PASS   = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_STOP   = 3'd4;

    localparam logic [24:0] MAXP = 25'(MAX_PACKET_BYTES);
    localparam logic [20:0] MAXO = 21'(MAX_OUT_BYTES);

    logic            in_valid_reg;
    in_beat_t        in_data_reg;
    logic [18:0]     cap_cfg_reg;
    logic [2:0]      phase_reg, phase_next;
    logic [2:0][7:0] hdr_reg, hdr_next;
    logic [19:0]     in_offset_reg, in_offset_next;
    logic [18:0]     out_count_reg, out_count_next;
    logic [31:0]     len_accum_reg, len_accum_next;
    logic [1:0]      len_cnt_reg, len_cnt_next;
    logic [19:0]     unit_rem_reg, unit_rem_next;

    logic                        step_en;
    logic [19:0]                 size_eff;
    logic [18:0]                 cap_eff;
    logic [7:0]                  b;
    logic [19:0]                 offset_inc;
    logic [31:0]                 su_nal;
    logic                        su_fail;
    logic [18:0]                 su_cnt3;
    logic                        annexb;
    logic                        emit;
    logic [18:0]                 cnt_after;
    logic [19:0]                 rem_dec;
    logic [2:0]                  nb;
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  end_status;

    function automatic logic nl_ok(input logic [19:0] o, input logic [18:0] c,
                                   input logic [19:0] sz, input logic [18:0] cp);
        nl_ok = (({1'b0, o} + 21'd4) < {1'b0, sz}) && (({1'b0, c} + 20'd3) < {1'b0, cp});
    endfunction

    assign step_en = in_valid_reg && rbuf_room;
    assign s_ready = !in_valid_reg || rbuf_room;
    assign push    = step_en;

    assign size_eff = ({5'd0, in_data_reg.packet_size} > MAXP) ? MAXP[19:0]
                                                                : in_data_reg.packet_size;
    assign cap_eff  = ({2'd0, cap_cfg_reg} > MAXO) ? MAXO[18:0] : cap_cfg_reg;

    assign b          = in_data_reg.in_byte;
    assign offset_inc = in_offset_reg + 20'd1;
    assign su_nal     = (phase_reg == PH_HEADER) ? {hdr_reg[0], hdr_reg[1], hdr_reg[2], b}
                                                 : {len_accum_reg[23:0], b};
    assign su_fail    = (({13'd0, offset_inc} + {1'b0, su_nal}) > {13'd0, size_eff}) ||
                        (({14'd0, out_count_reg} + 33'd3 + {1'b0, su_nal}) >
                         {14'd0, cap_eff});
    assign su_cnt3    = out_count_reg + 19'd3;
    assign annexb     = (hdr_reg[0] == SC_ZERO) && (hdr_reg[1] == SC_ZERO) &&
                        ((hdr_reg[2] == SC_ONE) ||
                         ((hdr_reg[2] == SC_ZERO) && (b == SC_ONE)));
    assign emit       = out_count_reg < cap_eff;
    assign cnt_after  = out_count_reg + {18'd0, emit};
    assign rem_dec    = unit_rem_reg - 20'd1;

    always_comb begin
        phase_next     = phase_reg;
        hdr_next       = hdr_reg;
        in_offset_next = in_offset_reg;
        out_count_next = out_count_reg;
        len_accum_next = len_accum_reg;
        len_cnt_next   = len_cnt_reg;
        unit_rem_next  = unit_rem_reg;
        nb             = 3'd0;
        bytes          = '0;

        if (in_offset_reg < size_eff) begin
            in_offset_next = offset_inc;
            case (phase_reg)
                PH_HEADER: begin
                    case (in_offset_reg[1:0])
                        2'd0: hdr_next[0] = b;
                        2'd1: hdr_next[1] = b;
                        2'd2: hdr_next[2] = b;
                        default: begin
                            if (annexb) begin
                                phase_next = PH_PASS;
                                bytes[0]   = hdr_reg[0];
                                bytes[1]   = hdr_reg[1];
                                bytes[2]   = hdr_reg[2];
                                bytes[3]   = b;
                                nb = (cap_eff >= 19'd4) ? 3'd4 : cap_eff[2:0];
                                out_count_next = {16'd0, nb};
                            end else begin
                                len_accum_next = su_nal;
                                if (size_eff > 20'd4 && cap_eff > 19'd3 && !su_fail) begin
                                    nb             = 3'd3;
                                    bytes[2]       = SC_ONE;
                                    out_count_next = su_cnt3;
                                    unit_rem_next  = su_nal[19:0];
                                    if (su_nal == 32'd0) begin
                                        phase_next = nl_ok(offset_inc, su_cnt3, size_eff,
                                                           cap_eff) ? PH_LEN : PH_STOP;
                                        len_accum_next = '0;
                                        len_cnt_next   = '0;
                                    end else begin
                                        phase_next = PH_BODY;
                                    end
                                end else begin
                                    phase_next = PH_STOP;
                                end
                            end
                        end
                    endcase
                end
                PH_PASS: begin
                    if (emit) begin
                        nb             = 3'd1;
                        bytes[0]       = b;
                        out_count_next = cnt_after;
                    end
                end
                PH_LEN: begin
                    len_accum_next = {len_accum_reg[23:0], b};
                    len_cnt_next   = len_cnt_reg + 2'd1;
                    if (len_cnt_reg == 2'd3) begin
                        len_cnt_next = '0;
                        if (!su_fail) begin
                            nb             = 3'd3;
                            bytes[2]       = SC_ONE;
                            out_count_next = su_cnt3;
                            unit_rem_next  = su_nal[19:0];
                            if (su_nal == 32'd0) begin
                                phase_next = nl_ok(offset_inc, su_cnt3, size_eff, cap_eff)
                                             ? PH_LEN : PH_STOP;
                                len_accum_next = '0;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end else begin
                            phase_next = PH_STOP;
                        end
                    end
                end
                PH_BODY: begin
                    if (emit) begin
                        nb       = 3'd1;
                        bytes[0] = b;
                    end
                    out_count_next = cnt_after;
                    unit_rem_next  = rem_dec;
                    if (rem_dec == 20'd0) begin
                        phase_next = nl_ok(offset_inc, cnt_after, size_eff, cap_eff)
                                     ? PH_LEN : PH_STOP;
                        len_accum_next = '0;
                        len_cnt_next   = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (out_count_next == 19'd0) begin
            end_status = STATUS_EMPTY;
        end else if (out_count_next < 19'd5) begin
            end_status = STATUS_SHORT;
        end else begin
            end_status = STATUS_OK;
        end

        push_set.num = nb + {2'd0, in_data_reg.packet_last};
        for (int k = 0; k < MAX_RESULTS; k++) begin
            push_set.beat[k] = '0;
            if (3'(k) < nb) begin
                push_set.beat[k].out_byte  = bytes[k];
                push_set.beat[k].out_valid = 1'b1;
            end else if (3'(k) == nb && in_data_reg.packet_last) begin
                push_set.beat[k].packet_end = 1'b1;
                push_set.beat[k].out_length = out_count_next;
                push_set.beat[k].status     = end_status;
            end
        end

        if (in_data_reg.packet_last) begin
            phase_next     = PH_HEADER;
            hdr_next       = '0;
            in_offset_next = '0;
            out_count_next = '0;
            len_accum_next = '0;
            len_cnt_next   = '0;
            unit_rem_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            cap_cfg_reg   <= CAP_RESET;
            phase_reg     <= PH_HEADER;
            hdr_reg       <= '0;
            in_offset_reg <= '0;
            out_count_reg <= '0;
            len_accum_reg <= '0;
            len_cnt_reg   <= '0;
            unit_rem_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_cfg_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (step_en) begin
                phase_reg     <= phase_next;
                hdr_reg       <= hdr_next;
                in_offset_reg <= in_offset_next;
                out_count_reg <= out_count_next;
                len_accum_reg <= len_accum_next;
                len_cnt_reg   <= len_cnt_next;
                unit_rem_reg  <= unit_rem_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

`ifndef SYNTHESIS
    a_header_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (out_count_reg == 19'd0))
        else $error("output counted before format decided");

    a_body_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (unit_rem_reg != 20'd0))
        else $error("unit body with no bytes left");

    a_last_gives_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && in_data_reg.packet_last) |=> (phase_reg == PH_HEADER &&
                                                  in_offset_reg == 20'd0))
        else $error("packet state not cleared after last beat");
`endif

endmodule

// ===== hdl/avcc_rbuf.sv =====
module avcc_rbuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  avcc_pkg::result_set_t push_set,
    output logic                  rbuf_room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output avcc_pkg::out_beat_t   m_data
);
    import avcc_pkg::*;

    localparam int PW = $clog2(RBUF_DEPTH);
    localparam int CW = $clog2(RBUF_DEPTH + 1);

    out_beat_t [RBUF_DEPTH-1:0] mem_reg;
    logic [PW-1:0]              wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [2:0]                 push_num;
    logic                       pop;

    assign push_num  = push ? push_set.num : 3'd0;
    assign pop       = m_valid && m_ready;
    assign m_valid   = count_reg != '0;
    assign m_data    = mem_reg[rd_ptr_reg];
    assign rbuf_room = count_reg <= CW'(RBUF_DEPTH - MAX_RESULTS);
    assign count_next = count_reg + CW'(push_num) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_num);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (3'(k) < push_num) begin
                mem_reg[wr_ptr_reg + PW'(k)] <= push_set.beat[k];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(RBUF_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_num != 3'd0) |-> ({1'b0, count_reg} + (CW+1)'(push_num) <=
                                (CW+1)'(RBUF_DEPTH)))
        else $error("result queue overflow");

    a_hold_until_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while waiting");
`endif

endmodule

// ===== hdl/avcc_to_annexb_converter.sv =====
// An accepted beat is registered, then its results are queued for m_.
// Throughput: one input beat per cycle while the result queue has room.
// A beat making several results (start code, header flush) is absorbed by an
// 8-entry result queue; a held beat waits while fewer than five entries are free.
// Reset (aresetn, synchronous, active low) clears all packet state and the
// queue and returns out_capacity to 262144.
module avcc_to_annexb_converter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  avcc_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output avcc_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [18:0]         cfg_wr_data
);
    import avcc_pkg::*;

    logic        rbuf_room;
    logic        push;
    result_set_t push_set;

    avcc_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rbuf_room   (rbuf_room),
        .push        (push),
        .push_set    (push_set)
    );

    avcc_rbuf u_rbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_set  (push_set),
        .rbuf_room (rbuf_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import avcc_pkg::*;

    localparam int unsigned RANDOM_BEATS = 200;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        HUNT_HDR,
        PASS_THRU,
        GET_LEN,
        COPY_NAL,
        HALTED
    } conv_phase_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_CAP
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  in_byte;
        logic [19:0] size;
        logic        last;
        logic [18:0] cap;
        logic        typed;
        logic [18:0] want_len;
        logic [1:0]  want_st;
    } row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_beat_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_beat_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [18:0] cfg_wr_data = '0;

    // converter state mirrored on the testbench side
    conv_phase_t     cv_phase;
    logic [7:0]      hdr [4];
    longint unsigned pkt_off;
    longint unsigned emitted;
    logic [31:0]     nal_len;
    longint unsigned nal_left;
    logic [18:0]     cap_reg;

    out_beat_t   exp_beats [$];
    logic [7:0]  pkt_q [$];
    logic [19:0] pkt_size;
    int unsigned errors = 0;
    bit          s_calm = 1'b0;

    row_t steps [27] = '{
        '{ROW_BEAT, 8'h00, 20'd2,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd2,       1'b1, 19'd0, 1'b1, 19'd0, STATUS_EMPTY},
        '{ROW_BEAT, 8'h00, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h01, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'hE5, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h7F, 20'd5,       1'b1, 19'd0, 1'b1, 19'd5, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h01, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'hAB, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd9,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd9,       1'b1, 19'd0, 1'b1, 19'd9, STATUS_OK},
        '{ROW_BEAT, 8'hFF, 20'd1048575, 1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'hFF, 20'd1048575, 1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'hFF, 20'd1048575, 1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'hFF, 20'd1048575, 1'b1, 19'd0, 1'b1, 19'd0, STATUS_EMPTY},
        '{ROW_CAP,  8'h00, 20'd0,       1'b0, 19'd4, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h00, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h01, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'hC0, 20'd5,       1'b0, 19'd0, 1'b0, 19'd0, STATUS_OK},
        '{ROW_BEAT, 8'h55, 20'd5,       1'b1, 19'd0, 1'b1, 19'd4, STATUS_SHORT}
    };

    avcc_to_annexb_converter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void push_beat(logic [7:0] b, logic valid, logic fin,
                                      logic [18:0] len, logic [1:0] st);
        out_beat_t r;
        r.out_byte   = b;
        r.out_valid  = valid;
        r.packet_end = fin;
        r.out_length = len;
        r.status     = st;
        exp_beats.push_back(r);
    endfunction

    function automatic void emit(logic [7:0] b);
        push_beat(b, 1'b1, 1'b0, 19'd0, STATUS_OK);
        emitted++;
    endfunction

    function automatic void clear_pkt();
        cv_phase = HUNT_HDR;
        hdr      = '{default: 8'h00};
        pkt_off  = 0;
        emitted  = 0;
        nal_len  = '0;
        nal_left = 0;
    endfunction

    function automatic void seek_len(longint unsigned size, longint unsigned cap);
        if (pkt_off + 4 < size && emitted + 3 < cap) begin
            cv_phase = GET_LEN;
            nal_len  = '0;
            nal_left = 0;
        end else begin
            cv_phase = HALTED;
        end
    endfunction

    function automatic void open_nal(longint unsigned size, longint unsigned cap);
        longint unsigned n;
        n = nal_len;
        if (pkt_off + n > size || emitted + 3 + n > cap) begin
            cv_phase = HALTED;
            return;
        end
        emit(SC_ZERO);
        emit(SC_ZERO);
        emit(SC_ONE);
        nal_left = n;
        if (n == 0)
            seek_len(size, cap);
        else
            cv_phase = COPY_NAL;
    endfunction

    function automatic void classify_hdr(longint unsigned size, longint unsigned cap);
        bit annexb;
        int k;
        annexb = hdr[0] == SC_ZERO && hdr[1] == SC_ZERO &&
                 (hdr[2] == SC_ONE || (hdr[2] == SC_ZERO && hdr[3] == SC_ONE));
        if (annexb) begin
            cv_phase = PASS_THRU;
            for (k = 0; k < 4; k++)
                if (emitted < cap)
                    emit(hdr[k]);
            return;
        end
        nal_len = {hdr[0], hdr[1], hdr[2], hdr[3]};
        if (4 < size && 3 < cap)
            open_nal(size, cap);
        else
            cv_phase = HALTED;
    endfunction

    function automatic void predict_beat(in_beat_t b);
        longint unsigned size;
        longint unsigned cap;
        longint unsigned off;
        logic [1:0]      st;
        size = b.packet_size;
        if (size > MAX_PACKET_BYTES)
            size = MAX_PACKET_BYTES;
        cap = cap_reg;
        if (cap > MAX_OUT_BYTES)
            cap = MAX_OUT_BYTES;
        if (pkt_off < size) begin
            off = pkt_off;
            pkt_off++;
            case (cv_phase)
                HUNT_HDR: begin
                    hdr[off[1:0]] = b.in_byte;
                    if (pkt_off >= 4)
                        classify_hdr(size, cap);
                end
                PASS_THRU: begin
                    if (emitted < cap)
                        emit(b.in_byte);
                end
                GET_LEN: begin
                    nal_len = {nal_len[23:0], b.in_byte};
                    nal_left++;
                    if (nal_left >= 4)
                        open_nal(size, cap);
                end
                COPY_NAL: begin
                    if (emitted < cap)
                        emit(b.in_byte);
                    if (nal_left > 0)
                        nal_left--;
                    if (nal_left == 0)
                        seek_len(size, cap);
                end
                default: ;
            endcase
        end
        if (b.packet_last) begin
            st = emitted == 0 ? STATUS_EMPTY : (emitted < 5 ? STATUS_SHORT : STATUS_OK);
            push_beat(8'h00, 1'b0, 1'b1, emitted[18:0], st);
            clear_pkt();
        end
    endfunction

    function automatic void build_packet();
        int unsigned units;
        int unsigned len;
        logic [31:0] pfx;
        pkt_q = {};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                units = $urandom_range(1, 3);
                repeat (units) begin
                    len = $urandom_range(0, 6);
                    pfx = len;
                    case ($urandom_range(0, 9))
                        0: pfx = $urandom;
                        1: pfx = len + $urandom_range(1, 4);
                        default: ;
                    endcase
                    pkt_q.push_back(pfx[31:24]);
                    pkt_q.push_back(pfx[23:16]);
                    pkt_q.push_back(pfx[15:8]);
                    pkt_q.push_back(pfx[7:0]);
                    repeat (len) pkt_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            5, 6: begin
                pkt_q.push_back(SC_ZERO);
                pkt_q.push_back(SC_ZERO);
                if ($urandom_range(0, 1) == 1)
                    pkt_q.push_back(SC_ZERO);
                pkt_q.push_back(SC_ONE);
                repeat ($urandom_range(0, 10)) pkt_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                repeat ($urandom_range(1, 12)) pkt_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        pkt_size = 20'(pkt_q.size());
        case ($urandom_range(0, 9))
            7: pkt_size = 20'($urandom_range(0, pkt_q.size()));
            8: pkt_size = 20'(pkt_q.size() + $urandom_range(1, 5));
            9: pkt_size = 20'($urandom_range(0, 20'hFFFFF));
            default: ;
        endcase
    endfunction

    function automatic logic [18:0] pick_cap(int unsigned n);
        if (n == 0)
            return 19'h7FFFF;
        if (n == 1)
            return CAP_RESET;
        case ($urandom_range(0, 5))
            0: return CAP_RESET;
            1: return 19'd4;
            2, 3: return 19'($urandom_range(5, 24));
            4: return 19'($urandom_range(25, 80));
            default: return 19'($urandom);
        endcase
    endfunction

    task automatic send_beat(input in_beat_t b);
        int unsigned gap;
        if ($urandom_range(0, 24) == 0)
            s_calm = !s_calm;
        gap = s_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(b);
    endtask

    // drain, let the pipeline settle, then write the capacity
    task automatic write_cap(input logic [18:0] v);
        s_valid <= 1'b0;
        while (exp_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = v;
    endtask

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %p", $time, m_data);
                errors++;
            end else begin
                want = exp_beats.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(m_data.out_byte));
                check_field("out_valid", 32'(want.out_valid), 32'(m_data.out_valid));
                check_field("packet_end", 32'(want.packet_end), 32'(m_data.packet_end));
                check_field("out_length", 32'(want.out_length), 32'(m_data.out_length));
                check_field("status", 32'(want.status), 32'(m_data.status));
            end
        end
    end

    initial begin
        int unsigned stall;
        bit          calm;
        calm = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 9);
            // hold ready low for a random stall
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        row_t        r;
        in_beat_t    b;
        out_beat_t   fin;
        int unsigned sent;
        int unsigned next_cfg;
        int unsigned cfg_phase;
        clear_pkt();
        cap_reg = CAP_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (steps[i]) begin
            r = steps[i];
            if (r.kind == ROW_CAP) begin
                write_cap(r.cap);
            end else begin
                b = '{in_byte: r.in_byte, packet_size: r.size, packet_last: r.last};
                send_beat(b);
                if (r.typed) begin
                    fin = exp_beats.pop_back();
                    fin = '{out_byte: 8'h00, out_valid: 1'b0, packet_end: 1'b1,
                            out_length: r.want_len, status: r.want_st};
                    exp_beats.push_back(fin);
                end
            end
        end

        sent      = 0;
        next_cfg  = 0;
        cfg_phase = 0;
        while (sent < RANDOM_BEATS) begin
            build_packet();
            for (int i = 0; i < pkt_q.size(); i++) begin
                if (sent == next_cfg) begin
                    write_cap(pick_cap(cfg_phase));
                    cfg_phase++;
                    next_cfg = sent + $urandom_range(15, 45);
                end
                b.in_byte     = pkt_q[i];
                b.packet_size = pkt_size;
                b.packet_last = (i == pkt_q.size() - 1);
                send_beat(b);
                sent++;
            end
        end

        s_valid <= 1'b0;
        while (exp_beats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
